/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expands to one labeled
// concurrent assertion that is clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SVMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/svmc_pkg.sv */
`default_nettype none

package svmc_pkg;

  typedef enum logic [2:0] {
    REQ_SET_PAIR    = 3'd0,
    REQ_STEP_UP     = 3'd1,
    REQ_STEP_DOWN   = 3'd2,
    REQ_MUTE        = 3'd3,
    REQ_TOGGLE_MUTE = 3'd4,
    REQ_RESTORE     = 3'd5
  } req_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEILING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_MUTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CROSS   = 2'd2;

  localparam logic [7:0] GAIN_CEILING_RST = 8'd255;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] left_value;
    logic [7:0] right_value;
    logic [7:0] step_size;
  } cmd_t;

  typedef struct packed {
    logic [7:0] gain_ceiling;
    logic       hard_mute_mode;
    logic       zero_cross_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] left_gain;
    logic [7:0] right_gain;
    logic [7:0] prev_left_gain;
    logic [7:0] prev_right_gain;
    logic       muted;
    logic       mute_line;
  } gain_state_t;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_word;
    logic        mute_line;
    logic        zero_cross_line;
    logic [7:0]  reported_left;
    logic [7:0]  reported_right;
    logic        is_muted;
  } result_t;

endpackage

`default_nettype wire

/* src/stereo_volume_mute_controller_core.sv */
`default_nettype none
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | req_type, left_value, right_value, step_size
// out      | out_valid/out_ready| frame_valid, frame_word, mute_line, zero_cross_line,
//          |                    | reported_left, reported_right, is_muted
// cfg      | cfg_we             | cfg_index, cfg_wdata (write only)
//
// A transaction is registered on input, decoded combinationally against the gain
// state, and its result lands in the output register. One transaction per cycle
// is sustained while out_ready is high; the gain state updates in the same
// cycle the result is registered, so back-to-back commands see each other.
// Reset (rst_n low, synchronous) clears both pipeline stages and loads the
// state and configuration reset values.
// When out_ready is low a valid result in the output register holds, and in_ready
// drops only while both the input register and the output register are occupied.

`include "assert_macros.svh"

module stereo_volume_mute_controller_core
  import svmc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [2:0]          in_req_type,
  input  wire  [7:0]          in_left_value,
  input  wire  [7:0]          in_right_value,
  input  wire  [7:0]          in_step_size,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_frame_valid,
  output logic [15:0]         out_frame_word,
  output logic                out_mute_line,
  output logic                out_zero_cross_line,
  output logic [7:0]          out_reported_left,
  output logic [7:0]          out_reported_right,
  output logic                out_is_muted,
  input  wire                 cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]          cfg_wdata
);

  cmd_t        cmd_r;
  logic        cmd_valid_r;
  cfg_t        cfg_r;
  gain_state_t state_r;
  gain_state_t state_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        out_valid_r;
  logic        advance;
  logic        fire;
  logic        in_fire;

  assign advance  = out_ready || !out_valid_r;
  assign fire     = cmd_valid_r && advance;
  assign in_ready = !cmd_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_ready) begin
      cmd_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= '{req_type: in_req_type, left_value: in_left_value,
                 right_value: in_right_value, step_size: in_step_size};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{gain_ceiling: GAIN_CEILING_RST, hard_mute_mode: 1'b0,
                 zero_cross_enable: 1'b1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_CEILING: cfg_r.gain_ceiling      <= cfg_wdata;
        CFG_HARD_MUTE:    cfg_r.hard_mute_mode    <= cfg_wdata[0];
        CFG_ZERO_CROSS:   cfg_r.zero_cross_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  svmc_cmd_unit u_cmd (
    .cmd (cmd_r),
    .cfg (cfg_r),
    .cur (state_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{left_gain: 8'd0, right_gain: 8'd0, prev_left_gain: 8'd0,
                   prev_right_gain: 8'd0, muted: 1'b0, mute_line: 1'b1};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_valid     = res_r.frame_valid;
  assign out_frame_word      = res_r.frame_word;
  assign out_mute_line       = res_r.mute_line;
  assign out_zero_cross_line = res_r.zero_cross_line;
  assign out_reported_left   = res_r.reported_left;
  assign out_reported_right  = res_r.reported_right;
  assign out_is_muted        = res_r.is_muted;

  `SVMC_ASSERT_NEXT(a_fire_loads_out, clk, rst_n, fire, out_valid_r,
                    "decoded transaction was not registered")
  `SVMC_ASSERT_NEXT(a_cmd_held, clk, rst_n, cmd_valid_r && !fire,
                    cmd_valid_r && $stable(cmd_r), "pending transaction lost")
  `SVMC_ASSERT_IMPL(a_muted_reports_zero, clk, rst_n, out_valid_r && res_r.is_muted,
                    (res_r.reported_left == 8'd0) && (res_r.reported_right == 8'd0),
                    "muted result reports nonzero gain")
  `SVMC_ASSERT_IMPL(a_no_frame_zero_word, clk, rst_n, out_valid_r && !res_r.frame_valid,
                    res_r.frame_word == 16'd0, "frame word set without a frame")

endmodule

`default_nettype wire

/* src/svmc_cmd_unit.sv */
`default_nettype none

module svmc_cmd_unit
  import svmc_pkg::*;
(
  input  wire cmd_t        cmd,
  input  wire cfg_t        cfg,
  input  wire gain_state_t cur,
  output gain_state_t      nxt,
  output result_t          res
);

  logic [8:0] sum_l;
  logic [8:0] sum_r;
  logic [7:0] up_l;
  logic [7:0] up_r;
  logic [7:0] dn_l;
  logic [7:0] dn_r;
  logic       pair_req;
  logic [7:0] pair_l;
  logic [7:0] pair_r;
  logic       restore_req;
  logic       leave_mute;
  logic       force_mute;
  logic       line_low;
  logic       pair_ok;
  gain_state_t st;

  always_comb begin
    sum_l = {1'b0, cur.left_gain} + {1'b0, cmd.step_size};
    sum_r = {1'b0, cur.right_gain} + {1'b0, cmd.step_size};
    up_l  = (sum_l > {1'b0, cfg.gain_ceiling}) ? cfg.gain_ceiling : sum_l[7:0];
    up_r  = (sum_r > {1'b0, cfg.gain_ceiling}) ? cfg.gain_ceiling : sum_r[7:0];
    dn_l  = (cur.left_gain > cmd.step_size) ? cur.left_gain - cmd.step_size : 8'd0;
    dn_r  = (cur.right_gain > cmd.step_size) ? cur.right_gain - cmd.step_size : 8'd0;
  end

  // Decode the command into a small set of actions, applied in the order the
  // behavior requires: leave mute, line low, pair write, restore, force mute.
  always_comb begin
    pair_req    = 1'b0;
    pair_l      = 8'd0;
    pair_r      = 8'd0;
    restore_req = 1'b0;
    leave_mute  = 1'b0;
    force_mute  = 1'b0;
    line_low    = 1'b0;
    case (req_t'(cmd.req_type))
      REQ_SET_PAIR: begin
        pair_req = 1'b1;
        pair_l   = cmd.left_value;
        pair_r   = cmd.right_value;
      end
      REQ_STEP_UP: begin
        leave_mute = cur.muted;
        pair_req   = (up_l != cur.left_gain) || (up_r != cur.right_gain);
        pair_l     = up_l;
        pair_r     = up_r;
      end
      REQ_STEP_DOWN: begin
        leave_mute = cur.muted;
        pair_req   = (dn_l != cur.left_gain) || (dn_r != cur.right_gain);
        pair_l     = dn_l;
        pair_r     = dn_r;
      end
      REQ_MUTE: begin
        force_mute = 1'b1;
        line_low   = cfg.hard_mute_mode;
        pair_req   = !cfg.hard_mute_mode;
      end
      REQ_TOGGLE_MUTE: begin
        if (cur.muted) begin
          leave_mute  = 1'b1;
          restore_req = !cfg.hard_mute_mode;
        end else begin
          force_mute = 1'b1;
          line_low   = cfg.hard_mute_mode;
          pair_req   = !cfg.hard_mute_mode;
        end
      end
      REQ_RESTORE: begin
        restore_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st      = cur;
    res     = '0;
    pair_ok = pair_req && (pair_l <= cfg.gain_ceiling) && (pair_r <= cfg.gain_ceiling);
    if (leave_mute) begin
      st.muted = 1'b0;
      if (cfg.hard_mute_mode) begin
        st.mute_line = 1'b1;
      end
    end
    if (line_low) begin
      st.mute_line = 1'b0;
    end
    if (pair_ok) begin
      res.frame_valid    = 1'b1;
      res.frame_word     = {pair_r, pair_l};
      st.prev_left_gain  = cur.left_gain;
      st.prev_right_gain = cur.right_gain;
      st.left_gain       = pair_l;
      st.right_gain      = pair_r;
      st.muted           = !cfg.hard_mute_mode && (pair_l == 8'd0) && (pair_r == 8'd0);
    end
    if (restore_req) begin
      res.frame_valid    = 1'b1;
      res.frame_word     = {cur.prev_right_gain, cur.prev_left_gain};
      st.left_gain       = cur.prev_left_gain;
      st.right_gain      = cur.prev_right_gain;
      st.prev_left_gain  = cur.left_gain;
      st.prev_right_gain = cur.right_gain;
    end
    if (force_mute) begin
      st.muted = 1'b1;
    end
    res.mute_line       = st.mute_line;
    res.zero_cross_line = cfg.zero_cross_enable;
    res.reported_left   = st.muted ? 8'd0 : st.left_gain;
    res.reported_right  = st.muted ? 8'd0 : st.right_gain;
    res.is_muted        = st.muted;
    nxt                 = st;
  end

endmodule

`default_nettype wire

/* verif/gain_state_checker.sv */
`default_nettype none

module gain_state_checker
  import svmc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire  [2:0]           in_req_type,
  input  wire  [7:0]           in_left_value,
  input  wire  [7:0]           in_right_value,
  input  wire  [7:0]           in_step_size,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wire                  out_frame_valid,
  input  wire  [15:0]          out_frame_word,
  input  wire                  out_mute_line,
  input  wire                  out_zero_cross_line,
  input  wire  [7:0]           out_reported_left,
  input  wire  [7:0]           out_reported_right,
  input  wire                  out_is_muted,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]           cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  cfg_t        gain_cfg;
  gain_state_t gains;
  logic        frame_sent;
  logic [15:0] frame_bits;
  result_t     expected_results[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function void reset_gain_model();
    gain_cfg.gain_ceiling      = GAIN_CEILING_RST;
    gain_cfg.hard_mute_mode    = 1'b0;
    gain_cfg.zero_cross_enable = 1'b1;
    gains.left_gain            = 8'd0;
    gains.right_gain           = 8'd0;
    gains.prev_left_gain       = 8'd0;
    gains.prev_right_gain      = 8'd0;
    gains.muted                = 1'b0;
    gains.mute_line            = 1'b1;
  endfunction

  function void load_pair(input logic [7:0] l, input logic [7:0] r);
    if (l > gain_cfg.gain_ceiling || r > gain_cfg.gain_ceiling) return;
    frame_sent            = 1'b1;
    frame_bits            = {r, l};
    gains.prev_left_gain  = gains.left_gain;
    gains.prev_right_gain = gains.right_gain;
    gains.left_gain       = l;
    gains.right_gain      = r;
    gains.muted           = !gain_cfg.hard_mute_mode && l == 8'd0 && r == 8'd0;
  endfunction

  function void swap_to_previous();
    logic [7:0] old_l;
    logic [7:0] old_r;
    old_l                 = gains.left_gain;
    old_r                 = gains.right_gain;
    frame_sent            = 1'b1;
    frame_bits            = {gains.prev_right_gain, gains.prev_left_gain};
    gains.left_gain       = gains.prev_left_gain;
    gains.right_gain      = gains.prev_right_gain;
    gains.prev_left_gain  = old_l;
    gains.prev_right_gain = old_r;
  endfunction

  function void engage_mute();
    if (gain_cfg.hard_mute_mode) begin
      gains.mute_line = 1'b0;
    end else begin
      load_pair(8'd0, 8'd0);
    end
    gains.muted = 1'b1;
  endfunction

  // A step command always leaves mute first, even if the gains end up unchanged.
  function void unmute_for_step();
    if (gains.muted) begin
      if (gain_cfg.hard_mute_mode) gains.mute_line = 1'b1;
      gains.muted = 1'b0;
    end
  endfunction

  function result_t predict_gain_cmd(input logic [2:0] req, input logic [7:0] lv,
                                     input logic [7:0] rv, input logic [7:0] st);
    logic [8:0] sum_l;
    logic [8:0] sum_r;
    logic [7:0] nl;
    logic [7:0] nr;
    result_t    res;
    frame_sent = 1'b0;
    frame_bits = 16'd0;
    case (req)
      REQ_SET_PAIR: load_pair(lv, rv);
      REQ_STEP_UP: begin
        unmute_for_step();
        sum_l = {1'b0, gains.left_gain} + {1'b0, st};
        sum_r = {1'b0, gains.right_gain} + {1'b0, st};
        nl = (sum_l > {1'b0, gain_cfg.gain_ceiling}) ? gain_cfg.gain_ceiling : sum_l[7:0];
        nr = (sum_r > {1'b0, gain_cfg.gain_ceiling}) ? gain_cfg.gain_ceiling : sum_r[7:0];
        if (nl != gains.left_gain || nr != gains.right_gain) load_pair(nl, nr);
      end
      REQ_STEP_DOWN: begin
        unmute_for_step();
        nl = (gains.left_gain > st) ? gains.left_gain - st : 8'd0;
        nr = (gains.right_gain > st) ? gains.right_gain - st : 8'd0;
        if (nl != gains.left_gain || nr != gains.right_gain) load_pair(nl, nr);
      end
      REQ_MUTE: engage_mute();
      REQ_TOGGLE_MUTE: begin
        if (gains.muted) begin
          if (gain_cfg.hard_mute_mode) begin
            gains.mute_line = 1'b1;
          end else begin
            swap_to_previous();
          end
          gains.muted = 1'b0;
        end else begin
          engage_mute();
        end
      end
      REQ_RESTORE: swap_to_previous();
      default: ;
    endcase
    res.frame_valid     = frame_sent;
    res.frame_word      = frame_sent ? frame_bits : 16'd0;
    res.mute_line       = gains.mute_line;
    res.zero_cross_line = gain_cfg.zero_cross_enable;
    res.reported_left   = gains.muted ? 8'd0 : gains.left_gain;
    res.reported_right  = gains.muted ? 8'd0 : gains.right_gain;
    res.is_muted        = gains.muted;
    return res;
  endfunction

  task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      reset_gain_model();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_CEILING: gain_cfg.gain_ceiling      = cfg_wdata;
          CFG_HARD_MUTE:    gain_cfg.hard_mute_mode    = cfg_wdata[0];
          CFG_ZERO_CROSS:   gain_cfg.zero_cross_enable = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction arrived with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_valid", want.frame_valid, out_frame_valid);
          check_field("frame_word", want.frame_word, out_frame_word);
          check_field("mute_line", want.mute_line, out_mute_line);
          check_field("zero_cross_line", want.zero_cross_line, out_zero_cross_line);
          check_field("reported_left", want.reported_left, out_reported_left);
          check_field("reported_right", want.reported_right, out_reported_right);
          check_field("is_muted", want.is_muted, out_is_muted);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_gain_cmd(in_req_type, in_left_value,
                                                    in_right_value, in_step_size));
      end
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

/* verif/stereo_volume_mute_controller_core_tb.sv */
`default_nettype none

module stereo_volume_mute_controller_core_tb;
  import svmc_pkg::*;

  // Request codes the block leaves unused; they still return a result.
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;
  localparam int         LONG_HOLD   = 60;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         NUM_PHASES  = 6;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_req_type    = 3'd0;
  logic [7:0]           in_left_value  = 8'd0;
  logic [7:0]           in_right_value = 8'd0;
  logic [7:0]           in_step_size   = 8'd0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 out_frame_valid;
  logic [15:0]          out_frame_word;
  logic                 out_mute_line;
  logic                 out_zero_cross_line;
  logic [7:0]           out_reported_left;
  logic [7:0]           out_reported_right;
  logic                 out_is_muted;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_GAIN_CEILING;
  logic [7:0]           cfg_wdata      = 8'd0;

  int         mismatches;
  int         pending;
  int         cycle_count   = 0;
  int         cmds_sent     = 0;
  bit         idle_on       = 1'b1;
  bit         long_hold_req = 1'b0;
  logic [7:0] cur_max       = GAIN_CEILING_RST;

  stereo_volume_mute_controller_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_left_value       (in_left_value),
    .in_right_value      (in_right_value),
    .in_step_size        (in_step_size),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_valid     (out_frame_valid),
    .out_frame_word      (out_frame_word),
    .out_mute_line       (out_mute_line),
    .out_zero_cross_line (out_zero_cross_line),
    .out_reported_left   (out_reported_left),
    .out_reported_right  (out_reported_right),
    .out_is_muted        (out_is_muted),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  gain_state_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_left_value       (in_left_value),
    .in_right_value      (in_right_value),
    .in_step_size        (in_step_size),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_valid     (out_frame_valid),
    .out_frame_word      (out_frame_word),
    .out_mute_line       (out_mute_line),
    .out_zero_cross_line (out_zero_cross_line),
    .out_reported_left   (out_reported_left),
    .out_reported_right  (out_reported_right),
    .out_is_muted        (out_is_muted),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls per transaction while idle_on is set, plus one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_cmd(input logic [2:0] req, input logic [7:0] lv,
                          input logic [7:0] rv, input logic [7:0] st);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req_type    = req;
    in_left_value  = lv;
    in_right_value = rv;
    in_step_size   = st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmds_sent++;
  endtask

  // Short pipeline: a few spare cycles after the last result are plenty.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] ceiling, input logic hard, input logic zc);
    drain();
    write_reg(CFG_GAIN_CEILING, ceiling);
    write_reg(CFG_HARD_MUTE, {7'd0, hard});
    write_reg(CFG_ZERO_CROSS, {7'd0, zc});
    cur_max = ceiling;
  endtask

  function automatic logic [7:0] pick_gain(input logic [7:0] limit);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'($urandom_range(0, limit));
    if (sel == 6) return limit;
    if (sel == 7) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random_phase(input int count, input int hold_at);
    int unsigned sel;
    logic [2:0]  req;
    logic [7:0]  step;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      sel = $urandom_range(0, 19);
      if (sel < 6) req = REQ_SET_PAIR;
      else if (sel < 9) req = REQ_STEP_UP;
      else if (sel < 12) req = REQ_STEP_DOWN;
      else if (sel < 14) req = REQ_MUTE;
      else if (sel < 17) req = REQ_TOGGLE_MUTE;
      else if (sel < 19) req = REQ_RESTORE;
      else req = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
      step = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 32));
      send_cmd(req, pick_gain(cur_max), pick_gain(cur_max), step);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed checks at the reset configuration, soft mute mode.
    send_cmd(REQ_STEP_DOWN, 8'd0, 8'd0, 8'd1);
    send_cmd(REQ_SET_PAIR, 8'd255, 8'd255, 8'd0);
    send_cmd(REQ_SET_PAIR, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_TOGGLE_MUTE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_STEP_UP, 8'd0, 8'd0, 8'd1);
    send_cmd(REQ_STEP_DOWN, 8'd0, 8'd0, 8'd255);
    send_cmd(REQ_STEP_UP, 8'd0, 8'd0, 8'd16);
    send_cmd(REQ_MUTE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_RESTORE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_SPARE_6, 8'd255, 8'd255, 8'd255);
    send_cmd(REQ_SPARE_7, 8'd0, 8'd0, 8'd0);

    // Lowered ceiling: out-of-range pairs are rejected, a restore skips the check.
    apply_config(8'd100, 1'b0, 1'b1);
    send_cmd(REQ_SET_PAIR, 8'd101, 8'd50, 8'd0);
    send_cmd(REQ_SET_PAIR, 8'd50, 8'd101, 8'd0);
    send_cmd(REQ_SET_PAIR, 8'd100, 8'd0, 8'd0);
    send_cmd(REQ_STEP_UP, 8'd0, 8'd0, 8'd200);
    send_cmd(REQ_RESTORE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_STEP_DOWN, 8'd0, 8'd0, 8'd1);

    // Hard mute through the dedicated line.
    apply_config(8'd255, 1'b1, 1'b0);
    send_cmd(REQ_MUTE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_TOGGLE_MUTE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_TOGGLE_MUTE, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_STEP_UP, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_SET_PAIR, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_MUTE, 8'd0, 8'd0, 8'd0);

    // Switching to soft mode while muted leaves the line where it was.
    apply_config(8'd255, 1'b0, 1'b1);
    send_cmd(REQ_TOGGLE_MUTE, 8'd0, 8'd0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin apply_config(8'd255, 1'b0, 1'b1); idle_on = 1'b1; end
        1: begin apply_config(8'd0, 1'b1, 1'b0); idle_on = 1'b0; end
        2: begin apply_config(8'd1, 1'b0, 1'b1); idle_on = 1'b1; end
        3: begin apply_config(8'($urandom_range(0, 255)), 1'b1, 1'b1); idle_on = 1'b1; end
        4: begin apply_config(8'd128, 1'b0, 1'b0); idle_on = 1'b0; end
        default: begin
          apply_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          idle_on = 1'b1;
        end
      endcase
      run_random_phase(250, (p == 2) ? 80 : -1);
    end

    drain();
    $display("Sent %0d commands over directed cases and %0d random configuration phases,",
             cmds_sent, NUM_PHASES);
    $display("including a %0d-cycle result hold-off; %0d field mismatches seen.",
             LONG_HOLD, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
